/* sv/margin_gradient_alpha_blend_assert.svh */
// Assertion macros shared by the margin gradient blend RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef MARGIN_GRADIENT_ALPHA_BLEND_ASSERT_SVH
`define MARGIN_GRADIENT_ALPHA_BLEND_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MGAB_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MGAB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/mgab_pkg.sv */
// Shared widths, register codes, pipeline payload types and step functions
// for the margin gradient blend. No dependencies.
`default_nettype none

package mgab_pkg;

  localparam int unsigned COORD_W        = 12;
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned SIZE_W         = 13;
  localparam int unsigned MARGIN_W       = 11;
  localparam int unsigned GW_W           = 12;
  localparam int unsigned PIX_W          = 32;
  localparam int unsigned CFG_W          = 32;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned IN_DATA_W      = 2 * COORD_W + PIX_W;
  localparam int unsigned OUT_DATA_W     = PIX_W;

  // Axis distances stay below 2^13, so the summed squares fit 27 bits.
  localparam int unsigned DIST_W      = 13;
  localparam int unsigned ROOT_W      = 14;
  localparam int unsigned SUM_W       = 2 * ROOT_W;
  localparam int unsigned REM_W       = ROOT_W + 1;
  localparam int unsigned ROOT_STAGES = ROOT_W / 2;
  localparam int unsigned QUOT_W      = 8;
  localparam int unsigned DIV_STAGES  = QUOT_W / 2;

  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MARGIN_SIZE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_GRADIENT_WIDTH = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TINT_COLOUR    = 3'd4;

  localparam logic [SIZE_W-1:0]   RST_SCREEN_WIDTH   = 13'd1024;
  localparam logic [SIZE_W-1:0]   RST_SCREEN_HEIGHT  = 13'd768;
  localparam logic [MARGIN_W-1:0] RST_MARGIN_SIZE    = 11'd64;
  localparam logic [GW_W-1:0]     RST_GRADIENT_WIDTH = 12'd4;
  localparam logic [PIX_W-1:0]    RST_TINT_COLOUR    = 32'h6800_0000;

  typedef struct packed {
    logic [SIZE_W-1:0]   screen_width;
    logic [SIZE_W-1:0]   screen_height;
    logic [MARGIN_W-1:0] margin_size;
    logic [GW_W-1:0]     gradient_width;
    logic [PIX_W-1:0]    tint_colour;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]  under;
    logic              x_mid;
    logic              y_mid;
    logic [DIST_W-1:0] dx;
    logic [DIST_W-1:0] dy;
    logic [SUM_W-1:0]  sum;
  } geom_t;

  // val holds the radicand bits not yet consumed, top pair first.
  typedef struct packed {
    logic [PIX_W-1:0]  under;
    logic              x_mid;
    logic              y_mid;
    logic [DIST_W-1:0] dx;
    logic [DIST_W-1:0] dy;
    logic [SUM_W-1:0]  val;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [QUOT_W-1:0] dq;
    logic [GW_W-1:0]   drem;
  } root_t;

  // One digit of the restoring square root.
  function automatic root_t sqrt_step(input root_t p);
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] trial;
    root_t            q;
    q     = p;
    rs    = {p.rem, p.val[SUM_W-1 -: 2]};
    trial = {1'b0, p.root, 2'b01};
    if (rs >= trial) begin
      q.rem  = REM_W'(rs - trial);
      q.root = {p.root[ROOT_W-2:0], 1'b1};
    end else begin
      q.rem  = rs[REM_W-1:0];
      q.root = {p.root[ROOT_W-2:0], 1'b0};
    end
    q.val = {p.val[SUM_W-3:0], 2'b00};
    return q;
  endfunction

  // One quotient bit of the restoring divide for the gradient step.
  function automatic root_t div_step(input root_t p, input logic b,
                                     input logic [GW_W-1:0] d);
    logic [GW_W:0] t;
    root_t         q;
    q = p;
    t = {p.drem, b};
    if (t >= {1'b0, d}) begin
      q.drem = GW_W'(t - {1'b0, d});
      q.dq   = {p.dq[QUOT_W-2:0], 1'b1};
    end else begin
      q.drem = t[GW_W-1:0];
      q.dq   = {p.dq[QUOT_W-2:0], 1'b0};
    end
    return q;
  endfunction

  function automatic logic [7:0] blend_channel(input logic [7:0] fa,
                                               input logic [7:0] fg,
                                               input logic [7:0] bg);
    logic [16:0] wf;
    logic [16:0] wb;
    logic [16:0] acc;
    wf  = 17'(8'hFF - fa);
    wb  = 17'(fa) + 17'd1;
    acc = wf * 17'(fg) + wb * 17'(bg);
    return acc[15:8];
  endfunction

endpackage

`default_nettype wire

/* sv/mgab_cfg.sv */
// Configuration register file for the margin gradient blend.
// Depends on mgab_pkg for register codes, widths and reset values.
`default_nettype none

module mgab_cfg import mgab_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.screen_width   <= RST_SCREEN_WIDTH;
      regs_r.screen_height  <= RST_SCREEN_HEIGHT;
      regs_r.margin_size    <= RST_MARGIN_SIZE;
      regs_r.gradient_width <= RST_GRADIENT_WIDTH;
      regs_r.tint_colour    <= RST_TINT_COLOUR;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCREEN_WIDTH:   regs_r.screen_width   <= cfg_wdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT:  regs_r.screen_height  <= cfg_wdata[SIZE_W-1:0];
        REG_MARGIN_SIZE:    regs_r.margin_size    <= cfg_wdata[MARGIN_W-1:0];
        REG_GRADIENT_WIDTH: regs_r.gradient_width <= cfg_wdata[GW_W-1:0];
        REG_TINT_COLOUR:    regs_r.tint_colour    <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs_r;

endmodule

`default_nettype wire

/* sv/mgab_geom.sv */
// Front of the pipeline: axis distances to the inner box, then the summed squares.
// Depends on mgab_pkg for cfg_t and geom_t.
`default_nettype none

module mgab_geom import mgab_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] in_x,
  input  wire logic [COORD_W-1:0] in_y,
  input  wire logic [PIX_W-1:0]   in_under,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output geom_t                   out_data
);

  localparam int unsigned S_W = SIZE_W + 2;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((33'd1 << COORD_BITS) - 33'd1);

  typedef struct packed {
    logic              mid;
    logic [DIST_W-1:0] d;
  } axis_t;

  typedef struct packed {
    logic [PIX_W-1:0]  under;
    logic              x_mid;
    logic              y_mid;
    logic [DIST_W-1:0] dx;
    logic [DIST_W-1:0] dy;
  } stage_a_t;

  // Outside the box's range the distance is never negative, so the low bits suffice.
  function automatic axis_t axis_dist(input logic [COORD_W-1:0] p,
                                      input logic [MARGIN_W-1:0] m,
                                      input logic [SIZE_W-1:0] size);
    logic signed [S_W-1:0] ps;
    logic signed [S_W-1:0] ms;
    logic signed [S_W-1:0] stop;
    logic signed [S_W-1:0] d;
    logic                  below;
    axis_t                 a;
    ps     = signed'(S_W'(p));
    ms     = signed'(S_W'(m));
    stop   = signed'(S_W'(size)) - ms;
    below  = ps < ms;
    d      = below ? ms - ps : ps - stop;
    a.mid  = !below && (ps < stop);
    a.d    = d[DIST_W-1:0];
    return a;
  endfunction

  logic                  a_vld_r;
  stage_a_t              a_r;
  stage_a_t              a_nxt;
  logic                  b_vld_r;
  geom_t                 b_r;
  geom_t                 b_nxt;
  logic                  a_ready;
  logic                  b_ready;
  axis_t                 ax;
  axis_t                 ay;
  logic [2*DIST_W-1:0]   sq_x;
  logic [2*DIST_W-1:0]   sq_y;

  assign b_ready  = !b_vld_r || out_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    ax          = axis_dist(in_x & CMASK, cfg.margin_size, cfg.screen_width);
    ay          = axis_dist(in_y & CMASK, cfg.margin_size, cfg.screen_height);
    a_nxt.under = in_under;
    a_nxt.x_mid = ax.mid;
    a_nxt.y_mid = ay.mid;
    a_nxt.dx    = ax.d;
    a_nxt.dy    = ay.d;
  end

  always_comb begin
    sq_x        = a_r.dx * a_r.dx;
    sq_y        = a_r.dy * a_r.dy;
    b_nxt.under = a_r.under;
    b_nxt.x_mid = a_r.x_mid;
    b_nxt.y_mid = a_r.y_mid;
    b_nxt.dx    = a_r.dx;
    b_nxt.dy    = a_r.dy;
    b_nxt.sum   = SUM_W'(sq_x) + SUM_W'(sq_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_ready) a_vld_r <= in_valid;
      if (b_ready) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) a_r <= a_nxt;
    if (b_ready) b_r <= b_nxt;
  end

  assign out_valid = b_vld_r;
  assign out_data  = b_r;

endmodule

`default_nettype wire

/* sv/mgab_root.sv */
// Square root pipeline, two result bits per stage, with the gradient step
// divide riding along in the first stages. Depends on mgab_pkg and the assert header.
`default_nettype none
`include "margin_gradient_alpha_blend_assert.svh"

module mgab_root import mgab_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  geom_t     in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output root_t     out_data
);

  localparam int unsigned LAST = ROOT_STAGES - 1;

  root_t                     stg_r   [ROOT_STAGES];
  root_t                     stg_nxt [ROOT_STAGES];
  root_t                     stg_in  [ROOT_STAGES];
  logic [ROOT_STAGES-1:0]    vld_r;
  logic [ROOT_STAGES-1:0]    vld_in;
  logic [ROOT_STAGES:0]      rdy;
  root_t                     init;
  logic [QUOT_W-1:0]         dvd;

  // The step is (255 - alpha) / gradient_width; the divisor comes straight from the
  // register, which the user must hold still while beats are in flight (not enforced).
  assign dvd = 8'hFF - cfg.tint_colour[PIX_W-1 -: QUOT_W];

  always_comb begin
    init.under = in_data.under;
    init.x_mid = in_data.x_mid;
    init.y_mid = in_data.y_mid;
    init.dx    = in_data.dx;
    init.dy    = in_data.dy;
    init.val   = in_data.sum;
    init.rem   = '0;
    init.root  = '0;
    init.dq    = '0;
    init.drem  = '0;
  end

  assign rdy[ROOT_STAGES] = out_ready;
  assign in_ready         = rdy[0];

  for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign stg_in[j] = init;
      assign vld_in[j] = in_valid;
    end else begin : g_next
      assign stg_in[j] = stg_r[j-1];
      assign vld_in[j] = vld_r[j-1];
    end

    if (j < DIV_STAGES) begin : g_div
      localparam int unsigned HI = QUOT_W - 1 - 2 * j;
      always_comb begin
        stg_nxt[j] = div_step(div_step(sqrt_step(sqrt_step(stg_in[j])),
                                       dvd[HI], cfg.gradient_width),
                              dvd[HI-1], cfg.gradient_width);
      end
    end else begin : g_sqrt
      always_comb begin
        stg_nxt[j] = sqrt_step(sqrt_step(stg_in[j]));
      end
    end

    assign rdy[j] = !vld_r[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) stg_r[j] <= stg_nxt[j];
    end
  end

  assign out_valid = vld_r[LAST];
  assign out_data  = stg_r[LAST];

  `MGAB_ASSERT_IMPL(a_root_rem_bound, vld_r[LAST], stg_r[LAST].rem <= {stg_r[LAST].root, 1'b0}, "square root remainder above twice the root")
  `MGAB_ASSERT_NEXT(a_root_hold, vld_r[LAST] && !out_ready, vld_r[LAST] && $stable(stg_r[LAST]), "stalled root beat changed or dropped")

endmodule

`default_nettype wire

/* sv/mgab_blend.sv */
// Back of the pipeline: distance select, band test and tint alpha, then the
// per-channel blend into the output register. Depends on mgab_pkg and the assert header.
`default_nettype none
`include "margin_gradient_alpha_blend_assert.svh"

module mgab_blend import mgab_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  root_t            in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_band
);

  typedef struct packed {
    logic [PIX_W-1:0] under;
    logic             band;
    logic [7:0]       na;
  } stage_d_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             band;
  } stage_e_t;

  logic              d_vld_r;
  stage_d_t          d_r;
  stage_d_t          d_nxt;
  logic              e_vld_r;
  stage_e_t          e_r;
  stage_e_t          e_nxt;
  logic              d_ready;
  logic              e_ready;
  logic [ROOT_W-1:0] dist_sel;
  logic [QUOT_W-1:0] step;
  logic [15:0]       prod;
  logic [7:0]        r;
  logic [7:0]        g;
  logic [7:0]        b;

  assign e_ready  = !e_vld_r || out_ready;
  assign d_ready  = !d_vld_r || e_ready;
  assign in_ready = d_ready;

  // Edge bands use the single axis distance; corners use the root.
  always_comb begin
    if (in_data.x_mid) begin
      dist_sel = ROOT_W'(in_data.dy);
    end else if (in_data.y_mid) begin
      dist_sel = ROOT_W'(in_data.dx);
    end else begin
      dist_sel = in_data.root;
    end
    step        = (cfg.gradient_width == '0) ? '0 : in_data.dq;
    prod        = step * dist_sel[7:0];
    d_nxt.under = in_data.under;
    d_nxt.band  = !(in_data.x_mid && in_data.y_mid) &&
                  (dist_sel <= ROOT_W'(cfg.gradient_width));
    d_nxt.na    = cfg.tint_colour[31:24] + prod[7:0];
  end

  always_comb begin
    r           = blend_channel(d_r.na, cfg.tint_colour[23:16], d_r.under[23:16]);
    g           = blend_channel(d_r.na, cfg.tint_colour[15:8],  d_r.under[15:8]);
    b           = blend_channel(d_r.na, cfg.tint_colour[7:0],   d_r.under[7:0]);
    e_nxt.band  = d_r.band;
    e_nxt.pixel = d_r.band ? {8'h00, r, g, b} : d_r.under;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      if (d_ready) d_vld_r <= in_valid;
      if (e_ready) e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) d_r <= d_nxt;
    if (e_ready) e_r <= e_nxt;
  end

  assign out_valid = e_vld_r;
  assign out_pixel = e_r.pixel;
  assign out_band  = e_r.band;

  `MGAB_ASSERT_IMPL(a_band_alpha_zero, e_vld_r && e_r.band, e_r.pixel[PIX_W-1 -: 8] == 8'h00, "blended pixel carries nonzero alpha")

endmodule

`default_nettype wire

/* sv/margin_gradient_alpha_blend.sv */
// Margin gradient alpha blend, top level.
// Stream in: one beat per pixel on in_* carrying the coordinate and the
// background pixel. Stream out: one beat per input beat on out_*, in order,
// carrying the blended pixel in tdata and the in-band flag in tuser.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 screen
// width, 1 screen height, 2 margin, 3 gradient width, 4 tint); write only
// while no beat is in flight. Writes to other indexes are ignored.
// From an accepted input beat to out_tvalid, a beat passes through two
// geometry stages (axis distances, squares), seven square root stages at
// two root bits each, and two blend stages, the last being the output
// register. Throughput is one beat per cycle while the output is not stalled.
// When the receiver stalls, each stage holds its beat and in_tready falls
// only once every stage between input and output is occupied; empty
// stages keep filling meanwhile.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register reset values.
// Depends on mgab_pkg, mgab_cfg, mgab_geom, mgab_root and mgab_blend.
`default_nettype none

module margin_gradient_alpha_blend import mgab_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pixel_x [11:0], pixel_y [23:12], under_pixel [55:24]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // pixel_out [31:0]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // in_band [0]
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  cfg_t  cfg;
  logic  geom_valid;
  logic  geom_ready;
  geom_t geom_data;
  logic  root_valid;
  logic  root_ready;
  root_t root_data;

  mgab_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mgab_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (in_tdata[COORD_W-1:0]),
    .in_y      (in_tdata[2*COORD_W-1:COORD_W]),
    .in_under  (in_tdata[IN_DATA_W-1:2*COORD_W]),
    .out_valid (geom_valid),
    .out_ready (geom_ready),
    .out_data  (geom_data)
  );

  mgab_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (geom_valid),
    .in_ready  (geom_ready),
    .in_data   (geom_data),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_data)
  );

  mgab_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_data   (root_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_band  (out_tuser)
  );

endmodule

`default_nettype wire
